// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam logic [2:0] OP_CREATE     = 3'd0;
    localparam logic [2:0] OP_CREATE_IRQ = 3'd1;
    localparam logic [2:0] OP_DELAY      = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    localparam logic [2:0] ST_SUSPENDED   = 3'd0;
    localparam logic [2:0] ST_READY       = 3'd1;
    localparam logic [2:0] ST_RUNNING     = 3'd2;
    localparam logic [2:0] ST_WAITING     = 3'd3;
    localparam logic [2:0] ST_INTERRUPTED = 3'd4;

    localparam logic [7:0] NEVER_PRIORITY = 8'd255;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  task_slot;
        logic [7:0]  task_priority_in;
        logic [23:0] entry_address;
        logic [23:0] caller_address;
        logic [15:0] delay_ticks;
    } in_word_t;

    typedef struct packed {
        logic        task_found;
        logic [2:0]  running_task;
        logic [23:0] resume_address;
        logic        timer_active;
    } out_word_t;

endpackage

// ===== rtl/core/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Task table of a small fixed-priority kernel with a scheduling pass.
// ----------------------------------------------------------------------------
// The input channel (s_) takes one operation word: create, create from an
// interrupt, delay or delete the current task, or a timer tick. The result
// channel (m_) returns one word per operation with the selected task, its
// resume address and whether any task is still delayed.
// Delay counters and resume addresses live in two RAMs with registered read.
// Small per-slot state (priority, state, delayed flag) is held in registers.
// A tick sweeps the delay RAM slot by slot, a read state then a write-back
// state for each slot. The scheduling pass searches one slot a cycle, then
// a final state takes the resume address and registers the result. A create
// that saves the caller into another slot first passes a second write state,
// and a tick first sweeps the delay RAM before the scheduling pass.
// One item is in work at a time; the next is accepted as soon as the result
// has moved into the output register, even while the receiver stalls. While
// that result waits, the next one holds in its last step and the input stops.
// After reset all slots are suspended with priority 255 and no task runs;
// enable_reg resets to one. The RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
    parameter int TASK_COUNT = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pts_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pts_pkg::out_word_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    localparam int AW = $clog2(TASK_COUNT);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(TASK_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK_RD, S_TICK_WR, S_SCAN, S_ADDR, S_DONE
    } state_t;

    state_t state_reg, state_next;
    pts_pkg::in_word_t in_reg, in_next;
    pts_pkg::out_word_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic enable_reg;

    logic [7:0] prio_reg [TASK_COUNT];
    logic [7:0] prio_next [TASK_COUNT];
    logic [2:0] st_reg [TASK_COUNT];
    logic [2:0] st_next [TASK_COUNT];
    logic [TASK_COUNT-1:0] dly_reg, dly_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic cur_valid_reg, cur_valid_next;
    logic [3:0] dcount_reg, dcount_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0] minp_reg, minp_next;
    logic [AW-1:0] best_reg, best_next;
    logic best_ok_reg, best_ok_next;

    logic d_we, r_we;
    logic [AW-1:0] d_waddr, d_raddr, r_waddr, r_raddr;
    logic [15:0] d_wdata, d_rdata;
    logic [23:0] r_wdata, r_rdata;

    pts_ram #(.WIDTH(16), .DEPTH(TASK_COUNT)) u_delay_ram (
        .aclk(aclk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
        .rd_addr(d_raddr), .rd_data(d_rdata)
    );

    pts_ram #(.WIDTH(24), .DEPTH(TASK_COUNT)) u_resume_ram (
        .aclk(aclk), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
        .rd_addr(r_raddr), .rd_data(r_rdata)
    );

    logic [15:0] dec;
    logic slot_ok;
    logic [AW-1:0] idx_a;
    logic [AW-1:0] slot_a;
    logic [AW-1:0] in_slot_a;
    logic [2:0] sc;
    logic elig;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign dec       = d_rdata - 16'd1;
    assign idx_a     = idx_reg[AW-1:0];
    assign slot_a    = AW'(s_data.task_slot);
    assign in_slot_a = AW'(in_reg.task_slot);
    assign slot_ok   = ({2'b0, s_data.task_slot} < 5'(TASK_COUNT));
    assign sc        = st_reg[idx_a];
    assign elig      = (sc == pts_pkg::ST_READY) || (sc == pts_pkg::ST_RUNNING)
                       || (sc == pts_pkg::ST_INTERRUPTED);

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        prio_next      = prio_reg;
        st_next        = st_reg;
        dly_next       = dly_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        dcount_next    = dcount_reg;
        idx_next       = idx_reg;
        minp_next      = minp_reg;
        best_next      = best_reg;
        best_ok_next   = best_ok_reg;
        d_we = 1'b0; d_waddr = cur_reg; d_wdata = s_data.delay_ticks; d_raddr = idx_a;
        r_we = 1'b0; r_waddr = cur_reg; r_wdata = s_data.caller_address;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                idx_next     = '0;
                minp_next    = pts_pkg::NEVER_PRIORITY;
                best_ok_next = 1'b0;
                if (s_valid && s_ready) begin
                    in_next    = s_data;
                    state_next = S_SCAN;
                    case (s_data.opcode)
                        pts_pkg::OP_CREATE, pts_pkg::OP_CREATE_IRQ: begin
                            if (s_data.opcode == pts_pkg::OP_CREATE && cur_valid_reg) begin
                                r_we = 1'b1;
                            end
                            if (slot_ok) begin
                                // A new task overrides any caller save to the same slot.
                                r_we              = 1'b1;
                                r_waddr           = slot_a;
                                r_wdata           = s_data.entry_address;
                                st_next[slot_a]   = pts_pkg::ST_READY;
                                prio_next[slot_a] = s_data.task_priority_in;
                            end
                        end
                        pts_pkg::OP_DELAY: begin
                            if (cur_valid_reg) begin
                                r_we = 1'b1;
                                d_we = 1'b1;
                                st_next[cur_reg] = pts_pkg::ST_WAITING;
                                if (!dly_reg[cur_reg]) begin
                                    dcount_next = dcount_reg + 4'd1;
                                end
                                dly_next[cur_reg] = 1'b1;
                            end
                        end
                        pts_pkg::OP_DELETE: begin
                            if (cur_valid_reg) begin
                                st_next[cur_reg] = pts_pkg::ST_SUSPENDED;
                            end
                        end
                        pts_pkg::OP_TICK: begin
                            state_next = S_TICK_RD;
                        end
                        default: begin
                        end
                    endcase
                    if (s_data.opcode == pts_pkg::OP_CREATE && cur_valid_reg && slot_ok
                        && slot_a != cur_reg) begin
                        // Two writes in one cycle: caller save goes first via a second pass.
                        r_waddr = cur_reg;
                        r_wdata = s_data.caller_address;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Second write of a create: the new task's entry address.
                r_we       = 1'b1;
                r_waddr    = in_slot_a;
                r_wdata    = in_reg.entry_address;
                state_next = S_SCAN;
            end
            S_TICK_RD: begin
                d_raddr    = idx_a;
                state_next = S_TICK_WR;
            end
            S_TICK_WR: begin
                if (dly_reg[idx_a]) begin
                    d_we    = 1'b1;
                    d_waddr = idx_a;
                    d_wdata = dec;
                    if (dec == 16'd0) begin
                        dcount_next    = dcount_reg - 4'd1;
                        st_next[idx_a] = pts_pkg::ST_READY;
                        dly_next[idx_a] = 1'b0;
                    end
                end
                if (idx_reg == LAST) begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_TICK_RD;
                end
            end
            S_SCAN: begin
                if (prio_reg[idx_a] < minp_reg && elig) begin
                    minp_next    = prio_reg[idx_a];
                    best_next    = idx_a;
                    best_ok_next = 1'b1;
                end
                if (idx_reg == LAST) begin
                    state_next = S_ADDR;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_ADDR: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.timer_active = |dly_reg;
                    out_next.task_found     = 1'b0;
                    out_next.running_task   = '0;
                    out_next.resume_address = '0;
                    if (enable_reg) begin
                        if (best_ok_reg) begin
                            st_next[best_reg]      = pts_pkg::ST_RUNNING;
                            cur_next               = best_reg;
                            cur_valid_next         = 1'b1;
                            out_next.task_found     = 1'b1;
                            out_next.running_task   = 3'(best_reg);
                            out_next.resume_address = r_rdata;
                        end else begin
                            cur_valid_next = 1'b0;
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        r_raddr = best_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
            dly_reg       <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            dcount_reg    <= '0;
            idx_reg       <= '0;
            best_ok_reg   <= 1'b0;
            for (int k = 0; k < TASK_COUNT; k++) begin
                prio_reg[k] <= pts_pkg::NEVER_PRIORITY;
                st_reg[k]   <= pts_pkg::ST_SUSPENDED;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            dly_reg       <= dly_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            dcount_reg    <= dcount_next;
            idx_reg       <= idx_next;
            best_ok_reg   <= best_ok_next;
            prio_reg      <= prio_next;
            st_reg        <= st_next;
        end
        in_reg   <= in_next;
        out_reg  <= out_next;
        minp_reg <= minp_next;
        best_reg <= best_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_found_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_data.task_found |-> cur_valid_reg
            && (3'(cur_reg) == m_data.running_task))
        else $error("current task disagrees with result");
    a_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (dly_reg == '0) |-> (dcount_reg == 4'd0) || (TASK_COUNT > 15))
        else $error("delayed count out of step");

endmodule
